// File: design/ssi_pkg.sv
`timescale 1ns / 1ps
package ssi_pkg;
    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_WIDTH  = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int OUT_IDX_W    = 6;
    // differences and cross products
    localparam int DIF_W        = COORD_WIDTH + 1;
    localparam int PRD_W        = 2 * DIF_W + 1;
    // numerator of the offset: nt * |d|
    localparam int NUM_W        = PRD_W + DIF_W;
    localparam int QUO_W        = NUM_W;
    localparam int DIV_CNT_W    = $clog2(NUM_W + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
    } seg_t;

    // one job from the front to the back: a segment to test and store
    typedef struct packed {
        seg_t             seg;
        logic [CNT_W-1:0] count;
    } job_t;

    // one result beat
    typedef struct packed {
        coord_t               hit_x;
        coord_t               hit_y;
        logic [OUT_IDX_W-1:0] idx;
        logic                 last;
    } res_t;
endpackage

// File: design/ssi_front.sv
`timescale 1ns / 1ps
// Front: accepts segments, snapshots the entry count, appends the segment
// to the store while it has room and queues a job for the back end.
module ssi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  ssi_pkg::seg_t                 seg_in,
    output logic                          job_valid,
    output ssi_pkg::job_t                 job,
    input  logic                          job_take,
    // store write port
    output logic                          wr_en,
    output logic [ssi_pkg::IDX_W-1:0]     wr_addr,
    output ssi_pkg::seg_t                 wr_data
);
    import ssi_pkg::*;

    localparam int QD = 2;

    job_t             q_reg [QD];
    logic [1:0]       q_cnt_reg;
    logic             q_rd_reg;
    logic             q_wr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             acc;

    // queue holds at most two jobs; stores are written in job order so a
    // later job never changes entries an earlier one reads
    assign full      = (q_cnt_reg == 2'(QD));
    assign acc       = push && !full;
    assign job_valid = (q_cnt_reg != 2'd0);
    assign job       = q_reg[q_rd_reg];

    assign wr_en   = acc && (count_reg < CNT_W'(MAX_SEGMENTS));
    assign wr_addr = count_reg[IDX_W-1:0];
    assign wr_data = seg_in;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[q_wr_reg].seg   <= seg_in;
            q_reg[q_wr_reg].count <= count_reg;
        end
    end

    // queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= 2'd0;
            q_rd_reg  <= 1'b0;
            q_wr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (acc)
                q_wr_reg <= ~q_wr_reg;
            if (job_take && job_valid)
                q_rd_reg <= ~q_rd_reg;
            q_cnt_reg <= q_cnt_reg + 2'(acc) - 2'(job_take && job_valid);
            if (wr_en)
                count_reg <= count_reg + 1'b1;
        end
    end

    // the queue never overflows or underflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 2'(QD)) else $error("job queue overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SEGMENTS)) else $error("count out of range");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("count did not advance on store write");
endmodule

// File: design/ssi_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ssi_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ssi_pkg::NUM_W-1:0]      num,
    input  logic [ssi_pkg::PRD_W-1:0]      den,
    output logic                           done,
    output logic [ssi_pkg::QUO_W-1:0]      quo,
    output logic [ssi_pkg::PRD_W-1:0]      rem
);
    import ssi_pkg::*;

    logic [NUM_W-1:0]     sh_reg;
    logic [PRD_W:0]       rem_reg;
    logic [PRD_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [PRD_W:0]       trial;
    logic [PRD_W:0]       diff;

    assign trial = {rem_reg[PRD_W-1:0], sh_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign quo   = sh_reg;
    assign rem   = rem_reg[PRD_W-1:0];

    // shift in one dividend bit, quotient bits shift into the low end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
            sh_reg   <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(NUM_W);
                sh_reg   <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                if (!diff[PRD_W])
                begin
                    rem_reg <= diff;
                    sh_reg  <= {sh_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    sh_reg  <= {sh_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("divider done held");
endmodule

// File: design/ssi_back.sv
`timescale 1ns / 1ps
// Back: walks the stored entries of one job, computes the cross products,
// divides for each hit coordinate and queues result beats.
module ssi_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    input  ssi_pkg::job_t             job,
    output logic                      job_take,
    input  logic                      wr_en,
    input  logic [ssi_pkg::IDX_W-1:0] wr_addr,
    input  ssi_pkg::seg_t             wr_data,
    output logic                      empty,
    input  logic                      pop,
    output ssi_pkg::res_t             res
);
    import ssi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_WAIT, S_PROD, S_CROSS, S_TEST,
        S_DIVX, S_WX, S_DIVY, S_WY, S_EMIT, S_FLUSH
    } state_t;

    typedef logic signed [DIF_W-1:0] dif_t;
    typedef logic signed [PRD_W-1:0] prd_t;

    seg_t            mem [MAX_SEGMENTS];
    seg_t            rd_reg;
    state_t          state_reg;
    job_t            job_reg;
    logic [CNT_W-1:0] k_reg;
    dif_t            d1x_reg, d1y_reg, d2x_reg, d2y_reg, rx_reg, ry_reg;
    prd_t            p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    prd_t            den_reg, nt_reg, nu_reg;
    logic [NUM_W-1:0] num_next;
    logic            div_start_reg;
    logic            div_done;
    logic [QUO_W-1:0] div_quo;
    logic [PRD_W-1:0] div_rem;
    coord_t          hx_reg;
    coord_t          hy_reg;
    res_t            pend_reg;
    logic            pend_vld_reg;
    res_t            obuf_reg;
    logic            ovld_reg;
    logic            out_load;
    logic            neg_sel;
    dif_t            dsel;
    logic [DIF_W-1:0] dabs;
    logic            rnd_up;
    logic [QUO_W-1:0] qr;
    coord_t          hit_c;

    // store write from the front, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[k_reg[IDX_W-1:0]];
    end

    // offset numerator nt * |d| for the coordinate in work
    assign dsel    = (state_reg == S_DIVX || state_reg == S_TEST) ? d1x_reg : d1y_reg;
    assign neg_sel = dsel[DIF_W-1];
    assign dabs    = neg_sel ? DIF_W'(-dsel) : DIF_W'(dsel);
    assign num_next = NUM_W'(nt_reg) * NUM_W'(dabs);

    ssi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_next),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // rounding: ties toward +infinity
    always_comb
    begin
        if (!neg_sel)
            rnd_up = ({div_rem, 1'b0} >= {1'b0, den_reg});
        else
            rnd_up = ({div_rem, 1'b0} > {1'b0, den_reg});
        qr    = div_quo + QUO_W'(rnd_up);
        hit_c = neg_sel ? coord_t'(-qr[COORD_WIDTH-1:0]) : coord_t'(qr[COORD_WIDTH-1:0]);
    end

    assign job_take = (state_reg == S_IDLE) && job_valid;
    assign empty    = !ovld_reg;
    assign res      = obuf_reg;

    // output register takes the pending hit in these two states
    assign out_load = pend_vld_reg
                      && ((state_reg == S_EMIT)
                          || (state_reg == S_FLUSH && (!ovld_reg || pop)));

    // sequencer, result holding and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            div_start_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
            ovld_reg      <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_load)
                ovld_reg <= 1'b1;
            else if (pop && ovld_reg)
                ovld_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        k_reg     <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    d1x_reg <= dif_t'(job_reg.seg.xe) - dif_t'(job_reg.seg.xs);
                    d1y_reg <= dif_t'(job_reg.seg.ye) - dif_t'(job_reg.seg.ys);
                    if (k_reg >= job_reg.count)
                        state_reg <= S_FLUSH;
                    else
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    d2x_reg   <= dif_t'(rd_reg.xe) - dif_t'(rd_reg.xs);
                    d2y_reg   <= dif_t'(rd_reg.ye) - dif_t'(rd_reg.ys);
                    rx_reg    <= dif_t'(rd_reg.xs) - dif_t'(job_reg.seg.xs);
                    ry_reg    <= dif_t'(rd_reg.ys) - dif_t'(job_reg.seg.ys);
                    state_reg <= S_CROSS;
                end
                S_CROSS:
                begin
                    p0_reg    <= prd_t'(d1x_reg) * prd_t'(d2y_reg);
                    p1_reg    <= prd_t'(d1y_reg) * prd_t'(d2x_reg);
                    p2_reg    <= prd_t'(rx_reg) * prd_t'(d2y_reg);
                    p3_reg    <= prd_t'(ry_reg) * prd_t'(d2x_reg);
                    p4_reg    <= prd_t'(rx_reg) * prd_t'(d1y_reg);
                    p5_reg    <= prd_t'(ry_reg) * prd_t'(d1x_reg);
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if ((p0_reg - p1_reg) < 0)
                    begin
                        den_reg <= p1_reg - p0_reg;
                        nt_reg  <= p3_reg - p2_reg;
                        nu_reg  <= p5_reg - p4_reg;
                    end
                    else
                    begin
                        den_reg <= p0_reg - p1_reg;
                        nt_reg  <= p2_reg - p3_reg;
                        nu_reg  <= p4_reg - p5_reg;
                    end
                    state_reg <= S_WX;
                end
                S_WX:
                begin
                    // range test on the normalized values
                    if (den_reg == '0 || nt_reg < 0 || nt_reg > den_reg
                        || nu_reg < 0 || nu_reg > den_reg)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIVX;
                    end
                end
                S_DIVX:
                begin
                    if (div_done)
                    begin
                        hx_reg        <= job_reg.seg.xs + hit_c;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (div_done)
                    begin
                        hy_reg    <= job_reg.seg.ys + hit_c;
                        state_reg <= S_WY;
                    end
                end
                S_WY:
                begin
                    // the previous hit is now known not to be last
                    if (!pend_vld_reg || !ovld_reg || pop)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (pend_vld_reg)
                    begin
                        obuf_reg.hit_x <= pend_reg.hit_x;
                        obuf_reg.hit_y <= pend_reg.hit_y;
                        obuf_reg.idx   <= pend_reg.idx;
                        obuf_reg.last  <= 1'b0;
                    end
                    pend_reg.hit_x <= hx_reg;
                    pend_reg.hit_y <= hy_reg;
                    pend_reg.idx   <= OUT_IDX_W'(k_reg);
                    pend_reg.last  <= 1'b0;
                    pend_vld_reg   <= 1'b1;
                    k_reg          <= k_reg + 1'b1;
                    state_reg      <= S_READ;
                end
                S_FLUSH:
                begin
                    if (!pend_vld_reg)
                        state_reg <= S_IDLE;
                    else if (!ovld_reg || pop)
                    begin
                        obuf_reg     <= '{hit_x: pend_reg.hit_x, hit_y: pend_reg.hit_y,
                                          idx: pend_reg.idx, last: 1'b1};
                        pend_vld_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_vld_reg) else $error("hit left pending");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && !pop |=> ovld_reg && $stable(obuf_reg.idx))
        else $error("result changed while waiting");
    a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVX || state_reg == S_DIVY)
        else $error("unexpected divider completion");
endmodule

// File: design/segment_store_intersector.sv
`timescale 1ns / 1ps
// Line segment intersector with a 64-entry segment store. Each pushed segment
// (signed Q12.4 endpoints) is tested against every stored segment in index
// order; each crossing yields a beat with the rounded crossing point and the
// stored index, and the final beat of a segment carries last. The segment is
// stored on acceptance if there is room. Each hit takes two passes of the
// one-bit-per-cycle divider, one for each coordinate, and the result side
// can stall the back end. A two-deep job queue lets up to two segments be
// accepted ahead of the back end.
module segment_store_intersector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ssi_pkg::coord_t     x_start,
    input  ssi_pkg::coord_t     y_start,
    input  ssi_pkg::coord_t     x_end,
    input  ssi_pkg::coord_t     y_end,
    output logic                empty,
    input  logic                pop,
    output ssi_pkg::coord_t     hit_x,
    output ssi_pkg::coord_t     hit_y,
    output logic [5:0]          stored_index,
    output logic                last
);
    import ssi_pkg::*;

    seg_t             seg_in;
    job_t             job;
    logic             job_valid;
    logic             job_take;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    seg_t             wr_data;
    res_t             res;

    assign seg_in = '{xs: x_start, ys: y_start, xe: x_end, ye: y_end};

    ssi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .seg_in    (seg_in),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ssi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign hit_x        = res.hit_x;
    assign hit_y        = res.hit_y;
    assign stored_index = res.idx;
    assign last         = res.last;
endmodule
